[rtl/nohd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// nohd_pkg
// shared types and constants for the note onset hysteresis detector
// ----------------------------------------------------------------------------
package nohd_pkg;

    localparam int NOTE_W     = 7;
    localparam int NOTE_DEPTH = 1 << NOTE_W;
    localparam int NOTE_COUNT = 128;
    localparam int VEL_W      = 7;
    localparam int STEP_W     = 24;
    localparam int KIND_W     = 2;
    localparam int LEVEL_W    = 7;

    localparam logic [VEL_W-1:0] OFF_VELOCITY = VEL_W'(64);

    localparam logic [KIND_W-1:0] KIND_OFF    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ON     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd2;

    // register indexes on the configuration port
    localparam logic [1:0] REG_ON_LEVEL  = 2'd0;
    localparam logic [1:0] REG_OFF_LEVEL = 2'd1;
    localparam logic [1:0] REG_MARGIN    = 2'd2;

    localparam logic [LEVEL_W-1:0] ON_LEVEL_RST  = LEVEL_W'(64);
    localparam logic [LEVEL_W-1:0] OFF_LEVEL_RST = LEVEL_W'(32);
    localparam logic [LEVEL_W-1:0] MARGIN_RST    = LEVEL_W'(20);

    typedef struct packed {
        logic [LEVEL_W-1:0] on_level;
        logic [LEVEL_W-1:0] off_level;
        logic [LEVEL_W-1:0] retrigger_margin;
    } cfg_t;

    typedef struct packed {
        logic [VEL_W-1:0]  velocity;
        logic [NOTE_W-1:0] note_number;
        logic [STEP_W-1:0] time_step;
    } in_item_t;

    typedef struct packed {
        logic [KIND_W-1:0] event_kind;
        logic [STEP_W-1:0] event_step;
        logic [NOTE_W-1:0] event_note;
        logic [VEL_W-1:0]  event_velocity;
        logic              last_of_run;
    } result_t;

    // results of one request, first in r0
    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } push_t;

endpackage
`default_nettype wire

[rtl/note_onset_hysteresis_detector.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// note_onset_hysteresis_detector
// per-note hysteresis onset detector turning velocity samples into note events
// ----------------------------------------------------------------------------
// Each request carries one note's measured velocity at one time step. The
// block keeps a sounding bit per note (cleared by reset) and the velocity of
// the open note-on in a 128 x 7 memory. An idle note above on_level gives a
// note-on; a sounding note at or below off_level gives a note-off with
// velocity 64; a sounding note reaching held + retrigger_margin gives a
// note-off followed by a note-on (last flag only on the second); otherwise a
// rise above the held velocity gives a velocity update. One request is
// accepted per cycle while the input is not stalled. A request stage
// registers the request and reads the held velocity memory; a decision
// stage decides, updates the per-note state and writes the result queue. A
// write to the same note by the previous request is forwarded, so
// back-to-back requests on one note are handled at full rate. Results leave
// one per cycle while the sink is ready, from a four-entry queue; the input
// stalls while that queue holds more than two results, so a retrigger's two
// results always fit. Registers are programmed over APB at byte addresses 0
// (on_level), 4 (off_level) and 8 (retrigger_margin); the user must write them only while idle, unchecked by the block.
// ----------------------------------------------------------------------------
module note_onset_hysteresis_detector (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // input requests
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,  // time_step[23:0], note_number[30:24],
                                       // velocity[37:31], zero pad [39:38]
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,  // event_step[23:0], event_note[30:24],
                                       // event_velocity[37:31], zero pad [39:38]
    output logic [1:0]       m_tuser,  // event_kind[1:0]
    output logic             m_tlast   // last_of_run
);

    nohd_pkg::cfg_t     cfg;
    nohd_pkg::in_item_t in_item;
    nohd_pkg::push_t    push;
    nohd_pkg::result_t  out_item;
    logic               room;

    // unpack the input request
    assign in_item.time_step   = s_tdata[23:0];
    assign in_item.note_number = s_tdata[30:24];
    assign in_item.velocity    = s_tdata[37:31];

    nohd_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // state lookup, decision and state update
    nohd_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_item  (in_item),
        .room     (room),
        .push     (push)
    );

    // result queue decouples the two sides
    nohd_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (out_item)
    );

    // pack the result
    assign m_tdata = {2'b00, out_item.event_velocity, out_item.event_note,
                      out_item.event_step};
    assign m_tuser = out_item.event_kind;
    assign m_tlast = out_item.last_of_run;

endmodule
`default_nettype wire

[rtl/nohd_cfg_regs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// nohd_cfg_regs
// apb register file holding the three threshold levels
// ----------------------------------------------------------------------------
module nohd_cfg_regs (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    output nohd_pkg::cfg_t          cfg
);

    nohd_pkg::cfg_t cfg_reg;
    nohd_pkg::cfg_t cfg_next;
    logic           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (paddr[3:2])
                nohd_pkg::REG_ON_LEVEL:  cfg_next.on_level =
                    pwdata[nohd_pkg::LEVEL_W-1:0];
                nohd_pkg::REG_OFF_LEVEL: cfg_next.off_level =
                    pwdata[nohd_pkg::LEVEL_W-1:0];
                nohd_pkg::REG_MARGIN:    cfg_next.retrigger_margin =
                    pwdata[nohd_pkg::LEVEL_W-1:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            nohd_pkg::REG_ON_LEVEL:  prdata = 32'(cfg_reg.on_level);
            nohd_pkg::REG_OFF_LEVEL: prdata = 32'(cfg_reg.off_level);
            nohd_pkg::REG_MARGIN:    prdata = 32'(cfg_reg.retrigger_margin);
            default:                 prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.on_level         <= nohd_pkg::ON_LEVEL_RST;
            cfg_reg.off_level        <= nohd_pkg::OFF_LEVEL_RST;
            cfg_reg.retrigger_margin <= nohd_pkg::MARGIN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

[rtl/nohd_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// nohd_core
// per-note state, held velocity memory and the onset decision
// ----------------------------------------------------------------------------
module nohd_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire nohd_pkg::cfg_t     cfg,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire nohd_pkg::in_item_t in_item,
    input  wire logic               room,
    output nohd_pkg::push_t         push
);

    logic                                  accept;
    logic                                  fire;
    logic                                  s1_valid_reg;
    logic                                  s1_valid_next;
    nohd_pkg::in_item_t                    s1_item_reg;

    logic [nohd_pkg::VEL_W-1:0]            held_mem [nohd_pkg::NOTE_DEPTH];
    logic [nohd_pkg::VEL_W-1:0]            rd_data_reg;
    logic                                  byp_hit_reg;
    logic [nohd_pkg::VEL_W-1:0]            byp_val_reg;
    logic [nohd_pkg::NOTE_DEPTH-1:0]       sounding_reg;
    logic [nohd_pkg::NOTE_DEPTH-1:0]       sounding_next;

    logic [nohd_pkg::VEL_W-1:0]            held;
    logic [nohd_pkg::VEL_W:0]              retrig_level;
    logic                                  note_ok;
    logic                                  snd;
    logic                                  held_wr;
    logic                                  snd_set;
    logic                                  snd_clr;
    nohd_pkg::result_t                     base;

    assign in_ready = !s1_valid_reg || room;
    assign accept   = in_valid && in_ready;
    assign fire     = s1_valid_reg && room;
    assign s1_valid_next = accept || (s1_valid_reg && !fire);

    // forward a write from the decision stage to a request that reads the same note
    assign held = byp_hit_reg ? byp_val_reg : rd_data_reg;
    assign retrig_level = {1'b0, held} + {1'b0, cfg.retrigger_margin};
    assign note_ok = int'(s1_item_reg.note_number) < nohd_pkg::NOTE_COUNT;
    assign snd     = sounding_reg[s1_item_reg.note_number];

    always_comb
    begin
        base.event_kind     = nohd_pkg::KIND_OFF;
        base.event_step     = s1_item_reg.time_step;
        base.event_note     = s1_item_reg.note_number;
        base.event_velocity = s1_item_reg.velocity;
        base.last_of_run    = 1'b1;

        push.count = 2'd0;
        push.r0    = base;
        push.r1    = base;
        held_wr    = 1'b0;
        snd_set    = 1'b0;
        snd_clr    = 1'b0;

        if (note_ok)
        begin
            if (!snd)
            begin
                if (s1_item_reg.velocity > cfg.on_level)
                begin
                    push.count          = 2'd1;
                    push.r0.event_kind  = nohd_pkg::KIND_ON;
                    held_wr             = 1'b1;
                    snd_set             = 1'b1;
                end
            end
            else if (s1_item_reg.velocity <= cfg.off_level)
            begin
                push.count             = 2'd1;
                push.r0.event_kind     = nohd_pkg::KIND_OFF;
                push.r0.event_velocity = nohd_pkg::OFF_VELOCITY;
                snd_clr                = 1'b1;
            end
            else if ({1'b0, s1_item_reg.velocity} >= retrig_level)
            begin
                // retrigger: off then a fresh on
                push.count             = 2'd2;
                push.r0.event_kind     = nohd_pkg::KIND_OFF;
                push.r0.event_velocity = nohd_pkg::OFF_VELOCITY;
                push.r0.last_of_run    = 1'b0;
                push.r1.event_kind     = nohd_pkg::KIND_ON;
                held_wr                = 1'b1;
            end
            else if (s1_item_reg.velocity > held)
            begin
                push.count          = 2'd1;
                push.r0.event_kind  = nohd_pkg::KIND_UPDATE;
                held_wr             = 1'b1;
            end
        end

        if (!fire)
        begin
            push.count = 2'd0;
            held_wr    = 1'b0;
            snd_set    = 1'b0;
            snd_clr    = 1'b0;
        end
    end

    always_comb
    begin
        sounding_next = sounding_reg;
        if (snd_set)
        begin
            sounding_next[s1_item_reg.note_number] = 1'b1;
        end
        if (snd_clr)
        begin
            sounding_next[s1_item_reg.note_number] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            sounding_reg <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            sounding_reg <= sounding_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= in_item;
            byp_hit_reg <= held_wr && (s1_item_reg.note_number == in_item.note_number);
            byp_val_reg <= s1_item_reg.velocity;
        end
    end

    always_ff @(posedge clk)
    begin
        if (held_wr)
        begin
            held_mem[s1_item_reg.note_number] <= s1_item_reg.velocity;
        end
        if (accept)
        begin
            rd_data_reg <= held_mem[in_item.note_number];
        end
    end

endmodule
`default_nettype wire

[rtl/nohd_out_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// nohd_out_fifo
// four-entry result queue, up to two writes and one read per cycle
// ----------------------------------------------------------------------------
module nohd_out_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire nohd_pkg::push_t   push,
    output logic                   room,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output nohd_pkg::result_t      out_item
);

    nohd_pkg::result_t mem_reg [4];
    logic [1:0]        wr_ptr_reg;
    logic [1:0]        wr_ptr_next;
    logic [1:0]        rd_ptr_reg;
    logic [1:0]        rd_ptr_next;
    logic [2:0]        count_reg;
    logic [2:0]        count_next;
    logic              pop;

    // room for a retrigger pair without looking at the read side
    assign room      = count_reg <= 3'd2;
    assign out_valid = count_reg != 3'd0;
    assign out_item  = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    assign wr_ptr_next = wr_ptr_reg + push.count;
    assign rd_ptr_next = rd_ptr_reg + {1'b0, pop};
    assign count_next  = count_reg + {1'b0, push.count} - {2'b00, pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_ptr_reg + 2'd1] <= push.r1;
        end
    end

endmodule
`default_nettype wire

[tb/nohd_tb_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// nohd_tb_pkg
// note state tracker and event checker for the onset detector testbench
// ----------------------------------------------------------------------------
// The tracker keeps its own copy of the level registers and of the per-note
// sounding bit and held velocity. Every accepted request is run through it
// and the note events it should cause are queued. Every event that leaves
// the block is checked field by field against the oldest queued one.
// ----------------------------------------------------------------------------
package nohd_tb_pkg;

    import nohd_pkg::*;

    class onset_tracker;

        cfg_t           levels;
        bit             sounding [NOTE_COUNT];
        bit [VEL_W-1:0] held_vel [NOTE_COUNT];
        result_t        expected_events [$];

        int errors;
        int requests;
        int events_seen;
        int note_ons;
        int note_offs;
        int updates;
        int retriggers;

        function new();
            levels.on_level         = ON_LEVEL_RST;
            levels.off_level        = OFF_LEVEL_RST;
            levels.retrigger_margin = MARGIN_RST;
            foreach (sounding[i])
            begin
                sounding[i] = 1'b0;
                held_vel[i] = '0;
            end
            errors      = 0;
            requests    = 0;
            events_seen = 0;
            note_ons    = 0;
            note_offs   = 0;
            updates     = 0;
            retriggers  = 0;
        endfunction

        // unknown indexes are dropped, values keep their low 7 bits
        function void set_level(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_ON_LEVEL:  levels.on_level         = value[LEVEL_W-1:0];
                REG_OFF_LEVEL: levels.off_level        = value[LEVEL_W-1:0];
                REG_MARGIN:    levels.retrigger_margin = value[LEVEL_W-1:0];
                default: ;
            endcase
        endfunction

        function void queue_event(logic [KIND_W-1:0] kind, in_item_t req,
                                  logic [VEL_W-1:0] vel, logic last);
            result_t ev;
            ev.event_kind     = kind;
            ev.event_step     = req.time_step;
            ev.event_note     = req.note_number;
            ev.event_velocity = vel;
            ev.last_of_run    = last;
            expected_events.push_back(ev);
            case (kind)
                KIND_ON:  note_ons++;
                KIND_OFF: note_offs++;
                default:  updates++;
            endcase
        endfunction

        function void take_request(in_item_t req);
            logic [NOTE_W-1:0] n;
            logic [VEL_W:0]    retrig_level;
            n = req.note_number;
            requests++;
            if (req.note_number >= NOTE_COUNT)
                return;
            if (!sounding[n])
            begin
                if (req.velocity > levels.on_level)
                begin
                    sounding[n] = 1'b1;
                    held_vel[n] = req.velocity;
                    queue_event(KIND_ON, req, req.velocity, 1'b1);
                end
            end
            else if (req.velocity <= levels.off_level)
            begin
                sounding[n] = 1'b0;
                queue_event(KIND_OFF, req, OFF_VELOCITY, 1'b1);
            end
            else
            begin
                // one bit wider so the sum never wraps
                retrig_level = {1'b0, held_vel[n]} + {1'b0, levels.retrigger_margin};
                if ({1'b0, req.velocity} >= retrig_level)
                begin
                    held_vel[n] = req.velocity;
                    retriggers++;
                    queue_event(KIND_OFF, req, OFF_VELOCITY, 1'b0);
                    queue_event(KIND_ON, req, req.velocity, 1'b1);
                end
                else if (req.velocity > held_vel[n])
                begin
                    held_vel[n] = req.velocity;
                    queue_event(KIND_UPDATE, req, req.velocity, 1'b1);
                end
            end
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                         $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_event(result_t got);
            result_t want;
            if (expected_events.size() == 0)
            begin
                $display(
                    "%0t: expected no event, got kind %0d step %0h note %0d vel %0d last %0b",
                    $time, got.event_kind, got.event_step, got.event_note,
                    got.event_velocity, got.last_of_run);
                errors++;
                return;
            end
            want = expected_events.pop_front();
            events_seen++;
            compare_field("event_kind", 32'(want.event_kind), 32'(got.event_kind));
            compare_field("event_step", 32'(want.event_step), 32'(got.event_step));
            compare_field("event_note", 32'(want.event_note), 32'(got.event_note));
            compare_field("event_velocity", 32'(want.event_velocity),
                          32'(got.event_velocity));
            compare_field("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
        endfunction

        function int pending();
            return expected_events.size();
        endfunction

    endclass

endpackage
`default_nettype wire

[tb/tb_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the note onset hysteresis detector
// ----------------------------------------------------------------------------
// Drives velocity requests into the block and checks every note event that
// comes out against a tracker holding its own per-note state. A short
// directed part walks through note-on, update, retrigger, note-off, the
// field extremes, zero margin, the unreachable retrigger sum and register
// writes with high bits set or at an unused address. Then several random
// phases run under different level settings, mostly velocities near the levels
// and held values of a small set of notes. Stream sides stall at random in most phases.
// ----------------------------------------------------------------------------
module tb_top;

    import nohd_pkg::*;
    import nohd_tb_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 5;
    localparam int SETTLE_CYCLES = 8;    // request and decision stages plus margin
    localparam int QUIET_LIMIT   = 600;  // cycles without any handshake
    localparam int PHASE_COUNT   = 8;
    localparam int PHASE_ITEMS   = 200;
    localparam int HOLD_CYCLES   = 60;

    // index with no register behind it
    localparam logic [1:0] REG_UNUSED = 2'd3;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;  // time_step[23:0], note_number[30:24],
                                 // velocity[37:31], zero pad [39:38]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;        // event_step[23:0], event_note[30:24],
                                 // event_velocity[37:31], zero pad [39:38]
    logic [1:0]  m_tuser;        // event_kind[1:0]
    logic        m_tlast;        // last_of_run

    onset_tracker tracker = new();

    // stall rates in percent, and a hold-off counted down by the sink
    int tx_idle_pct       = 35;
    int rx_idle_pct       = 35;
    int sink_hold_cycles  = 0;
    int level_settings    = 1;

    note_onset_hysteresis_detector dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // ------------------------------------------------------------------------
    // result sink: check what was taken at this edge, then pick next ready
    // ------------------------------------------------------------------------
    initial
    begin
        result_t got;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                got.event_kind     = m_tuser;
                got.event_step     = m_tdata[23:0];
                got.event_note     = m_tdata[30:24];
                got.event_velocity = m_tdata[37:31];
                got.last_of_run    = m_tlast;
                tracker.check_event(got);
            end
            if (sink_hold_cycles > 0)
            begin
                // long hold-off so the result queue fills and the input stalls
                m_tready <= 1'b0;
                sink_hold_cycles--;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: any stretch without a handshake beyond the limit is a hang
    // ------------------------------------------------------------------------
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: timeout, no handshake for %0d cycles, %0d events outstanding",
                 $time, QUIET_LIMIT, tracker.pending());
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------

    function automatic in_item_t make_request(int unsigned step, int unsigned note,
                                              int unsigned vel);
        in_item_t req;
        req.time_step   = step[STEP_W-1:0];
        req.note_number = note[NOTE_W-1:0];
        req.velocity    = vel[VEL_W-1:0];
        return req;
    endfunction

    // called at an edge; returns at the edge where the request was taken
    task automatic send_request(in_item_t req);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, req.velocity, req.note_number, req.time_step};
        do
            @(posedge clk);
        while (!s_tready);
        tracker.take_request(req);
    endtask

    // stop offering and wait until every expected event has come out, then
    // let the pipeline empty of requests that cause no event
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // setup, access, then idle before the next transfer
    task automatic apb_access(input bit wr, input logic [1:0] idx,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // write one register and read it back where one exists
    task automatic write_level(logic [1:0] idx, logic [31:0] value);
        logic [31:0] rd;
        logic [31:0] want;
        apb_access(1'b1, idx, value, rd);
        tracker.set_level(idx, value);
        if (idx != REG_UNUSED)
        begin
            want = {25'd0, value[LEVEL_W-1:0]};
            apb_access(1'b0, idx, '0, rd);
            if (rd !== want)
            begin
                $display("%0t: register %0d readback mismatch, expected 0x%0h, got 0x%0h",
                         $time, idx, want, rd);
                tracker.errors++;
            end
        end
    endtask

    task automatic program_levels(int unsigned on_lvl, int unsigned off_lvl,
                                  int unsigned margin);
        wait_for_drain();
        write_level(REG_ON_LEVEL, on_lvl);
        write_level(REG_OFF_LEVEL, off_lvl);
        write_level(REG_MARGIN, margin);
        level_settings++;
    endtask

    // velocities clustered around the thresholds of the current setting and
    // around the held value of the note, with some fully random ones
    function automatic int unsigned pick_velocity(logic [NOTE_W-1:0] n);
        int v;
        case ($urandom_range(9))
            0, 1:    v = int'($urandom_range(127));
            2, 3:    v = int'(tracker.levels.on_level) + int'($urandom_range(4)) - 2;
            4, 5:    v = int'(tracker.levels.off_level) + int'($urandom_range(4)) - 2;
            6, 7:    v = int'(tracker.held_vel[n]) + int'(tracker.levels.retrigger_margin)
                         + int'($urandom_range(2)) - 1;
            default: v = int'(tracker.held_vel[n]) + int'($urandom_range(3));
        endcase
        if (v < 0)
            v = 0;
        if (v > 127)
            v = 127;
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [NOTE_W-1:0] note_pool [8];
        int                pool_size;
        int unsigned       step_count;
        int unsigned       on_lvl;
        int unsigned       off_lvl;
        int unsigned       margin;
        logic [NOTE_W-1:0] n;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset levels: on 64, off 32, margin 20
        send_request(make_request(0, 0, 64));           // at on level, stays idle
        send_request(make_request(1, 0, 65));           // note-on
        send_request(make_request(2, 0, 65));           // no change
        send_request(make_request(3, 0, 70));           // velocity update
        send_request(make_request(4, 0, 90));           // exactly held + margin, retrigger
        send_request(make_request(5, 0, 33));           // just above off, no change
        send_request(make_request(6, 0, 32));           // note-off at off level
        send_request(make_request(32'hFF_FFFF, 127, 127));
        send_request(make_request(32'hFF_FFFF, 127, 127)); // held 127, sum past 127 unreachable
        send_request(make_request(32'hFF_FFFE, 127, 0));
        send_request(make_request(32'h80_0000, 64, 127));
        send_request(make_request(32'h7F_FFFF, 64, 0));

        // all zero: zero margin retriggers on any sounding velocity above off
        program_levels(0, 0, 0);
        send_request(make_request(10, 1, 0));           // zero never above zero
        send_request(make_request(11, 1, 1));           // note-on
        send_request(make_request(12, 1, 1));           // retrigger at equal velocity
        send_request(make_request(13, 1, 127));         // retrigger
        send_request(make_request(14, 1, 0));           // note-off

        // high bits of the write data are dropped; unused index is ignored
        wait_for_drain();
        write_level(REG_ON_LEVEL, 32'hFFFF_FF80 | 32'd100);
        write_level(REG_OFF_LEVEL, 32'h5555_5514);
        write_level(REG_MARGIN, 32'hFFFF_FFFF);
        write_level(REG_UNUSED, 32'h0000_0001);
        level_settings++;
        send_request(make_request(20, 2, 100));         // at on level, idle
        send_request(make_request(21, 2, 127));         // note-on
        send_request(make_request(22, 2, 21));          // just above off, no change
        send_request(make_request(23, 2, 20));          // note-off

        step_count = 100;
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            case (p)
                0: begin on_lvl = 64;  off_lvl = 32;  margin = 20;  end
                1: begin on_lvl = 0;   off_lvl = 0;   margin = 0;   end
                2: begin on_lvl = 100; off_lvl = 20;  margin = 127; end
                3: begin on_lvl = 40;  off_lvl = 60;  margin = 5;   end
                4: begin on_lvl = 127; off_lvl = 0;   margin = 0;   end
                5: begin on_lvl = 0;   off_lvl = 127; margin = 127; end
                default:
                begin
                    on_lvl  = $urandom_range(127);
                    off_lvl = $urandom_range(127);
                    margin  = $urandom_range(127);
                end
            endcase
            program_levels(on_lvl, off_lvl, margin);

            // one phase without any stalls on either side
            tx_idle_pct = (p == 1) ? 0 : 35;
            rx_idle_pct = (p == 1) ? 0 : 35;

            pool_size = $urandom_range(8, 1);
            foreach (note_pool[i])
                note_pool[i] = NOTE_W'($urandom_range(127));

            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (p == 3 && k == 100)
                begin
                    // keep offering while the sink holds off
                    tx_idle_pct      = 0;
                    sink_hold_cycles = HOLD_CYCLES;
                end
                if (p == 3 && k == 160)
                    tx_idle_pct = 35;

                if ($urandom_range(99) < 15)
                    n = NOTE_W'($urandom_range(127));
                else
                    n = note_pool[3'($urandom_range(pool_size - 1))];

                if ($urandom_range(99) < 10)
                    step_count = $urandom();
                else
                    step_count = step_count + $urandom_range(3);

                send_request(make_request(step_count, n, pick_velocity(n)));
            end
        end

        wait_for_drain();

        $display("covered %0d requests under %0d level settings, %0d events checked",
                 tracker.requests, level_settings, tracker.events_seen);
        $display("events: %0d note-on, %0d note-off, %0d updates, %0d retriggers, %0d errors",
                 tracker.note_ons, tracker.note_offs, tracker.updates,
                 tracker.retriggers, tracker.errors);
        if (tracker.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
`default_nettype wire

[files.f]
rtl/nohd_pkg.sv
rtl/nohd_cfg_regs.sv
rtl/nohd_core.sv
rtl/nohd_out_fifo.sv
rtl/note_onset_hysteresis_detector.sv
tb/nohd_tb_pkg.sv
tb/tb_top.sv
